/* rtl/pvc_pkg.sv */
// Package for the polar vector CORDIC core: datapath widths, the carried
// vector and sideband types, and the per-turn arctangent table.
// No dependencies.
`default_nettype none

package pvc_pkg;

	localparam int InW   = 32;  // input component width
	localparam int XW    = 36;  // signed CORDIC datapath width
	localparam int AW    = 32;  // angle accumulator, 2^32 per turn
	localparam int ShW   = 5;   // normalizing shift, 0..31
	localparam int TotW  = 6;   // fraction bits plus shift
	localparam int GW    = 30;  // scaled gain width
	localparam int XMagW = 34;  // magnitude bits of the final x
	localparam int MSplit = 17; // low part of x in the gain multiply
	localparam int ProdW = 65;  // product plus rounding half
	localparam int BrW   = 16;
	localparam int LenW  = 31;

	localparam int NumAtan = 30;
	localparam logic [63:0] GainQ30 = 64'd652032874;
	localparam logic [AW-1:0] HalfTurn = 32'h8000_0000;
	localparam logic [AW-1:0] BearingHalf = 32'h0000_8000;

	localparam logic [AW-1:0] AtanTurn32 [NumAtan] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [AW-1:0]        ang;
	} vec_t;

	typedef struct packed {
		logic           zero;
		logic [ShW-1:0] shift;
	} side_t;

endpackage

`default_nettype wire

/* rtl/pvc_norm.sv */
// Front end of the polar vector CORDIC core: magnitude, leading-zero shift,
// normalization and half-turn fold over three pipeline stages.
// Depends on pvc_pkg.
`default_nettype none

module pvc_norm (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic signed [pvc_pkg::InW-1:0]    x_raw,
	input  wire logic signed [pvc_pkg::InW-1:0]    z_raw,
	output logic                                   out_valid,
	output pvc_pkg::vec_t                          out_vec,
	output pvc_pkg::side_t                         out_side
);

	logic                             v_s1, v_s2;
	logic signed [pvc_pkg::InW-1:0]   x_s1, z_s1, x_s2, z_s2;
	logic [pvc_pkg::InW-1:0]          mag_s1;
	logic                             zero_s1, zero_s2;
	logic [pvc_pkg::ShW-1:0]          sh_s2;

	logic [pvc_pkg::InW:0]            xe, ze, xa, za;
	logic [pvc_pkg::InW-1:0]          mag_d;
	logic [pvc_pkg::InW-1:0]          m;
	logic [pvc_pkg::ShW-1:0]          sh_d;
	logic signed [pvc_pkg::XW-1:0]    xs, zs;
	pvc_pkg::vec_t                    vec_d;

	always_comb begin
		xe = {x_raw[pvc_pkg::InW-1], x_raw};
		ze = {z_raw[pvc_pkg::InW-1], z_raw};
		xa = x_raw[pvc_pkg::InW-1] ? ((pvc_pkg::InW+1)'(0) - xe) : xe;
		za = z_raw[pvc_pkg::InW-1] ? ((pvc_pkg::InW+1)'(0) - ze) : ze;
		mag_d = (za > xa) ? za[pvc_pkg::InW-1:0] : xa[pvc_pkg::InW-1:0];
	end

	// leading-zero search, halving steps
	always_comb begin
		m = mag_s1;
		sh_d = '0;
		for (int k = pvc_pkg::ShW - 1; k >= 0; k--) begin
			if ((m >> (pvc_pkg::InW - (1 << k))) == '0) begin
				m = m << (1 << k);
				sh_d = sh_d | pvc_pkg::ShW'(1 << k);
			end
		end
	end

	always_comb begin
		zs = $signed({{(pvc_pkg::XW-pvc_pkg::InW){z_s2[pvc_pkg::InW-1]}}, z_s2}) <<< sh_s2;
		xs = $signed({{(pvc_pkg::XW-pvc_pkg::InW){x_s2[pvc_pkg::InW-1]}}, x_s2}) <<< sh_s2;
		if (z_s2[pvc_pkg::InW-1]) begin
			vec_d.x   = -zs;
			vec_d.y   = -xs;
			vec_d.ang = pvc_pkg::HalfTurn;
		end else begin
			vec_d.x   = zs;
			vec_d.y   = xs;
			vec_d.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1           <= x_raw;
		z_s1           <= z_raw;
		mag_s1         <= mag_d;
		zero_s1        <= (x_raw == '0) && (z_raw == '0);
		x_s2           <= x_s1;
		z_s2           <= z_s1;
		sh_s2          <= sh_d;
		zero_s2        <= zero_s1;
		out_vec        <= vec_d;
		out_side.zero  <= zero_s2;
		out_side.shift <= sh_s2;
	end

endmodule

`default_nettype wire

/* rtl/pvc_cell.sv */
// One CORDIC vectoring iteration of the polar vector core, registered.
// Depends on pvc_pkg (vector types, arctangent table).
`default_nettype none

module pvc_cell #(
	parameter int STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire pvc_pkg::vec_t  in_vec,
	input  wire pvc_pkg::side_t in_side,
	output logic                out_valid,
	output pvc_pkg::vec_t       out_vec,
	output pvc_pkg::side_t      out_side
);

	logic signed [pvc_pkg::XW-1:0] xi, yi, dx, dy;
	pvc_pkg::vec_t                 vec_d;

	always_comb begin
		xi = $signed(in_vec.x);
		yi = $signed(in_vec.y);
		dx = xi >>> STEP;
		dy = yi >>> STEP;
		if (yi <= 0) begin
			vec_d.x   = xi - dy;
			vec_d.y   = yi + dx;
			vec_d.ang = in_vec.ang - pvc_pkg::AtanTurn32[STEP];
		end else begin
			vec_d.x   = xi + dy;
			vec_d.y   = yi - dx;
			vec_d.ang = in_vec.ang + pvc_pkg::AtanTurn32[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_vec  <= vec_d;
		out_side <= in_side;
	end

endmodule

`default_nettype wire

/* rtl/pvc_scale.sv */
// Back end of the polar vector CORDIC core: gain multiply in two partial
// products, rounding shift, saturation and bearing rounding. Depends on pvc_pkg.
`default_nettype none

module pvc_scale #(
	parameter int FRAC_BITS = 30
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire pvc_pkg::vec_t                in_vec,
	input  wire pvc_pkg::side_t               in_side,
	output logic                              done,
	output logic [pvc_pkg::BrW-1:0]           bearing,
	output logic [pvc_pkg::LenW-1:0]          length
);

	localparam logic [63:0] GainFull =
		(pvc_pkg::GainQ30 * (64'd1 << FRAC_BITS) + (64'd1 << 29)) >> 30;
	localparam logic [pvc_pkg::GW-1:0] Gain = GainFull[pvc_pkg::GW-1:0];
	localparam int HiW = pvc_pkg::XMagW - pvc_pkg::MSplit;

	logic                                   v_s1, v_s2;
	logic [HiW+pvc_pkg::GW-1:0]             ph_s1;
	logic [pvc_pkg::MSplit-1:0]             xl_s1;
	logic [pvc_pkg::TotW-1:0]               tot_s1, tot_s2;
	logic [pvc_pkg::AW-1:0]                 ang_s1, ang_s2;
	logic                                   zero_s1, zero_s2;
	logic [pvc_pkg::ProdW-1:0]              sum_s2;

	logic [pvc_pkg::XMagW-1:0]              xm;
	logic [pvc_pkg::MSplit+pvc_pkg::GW-1:0] pl;
	logic [pvc_pkg::ProdW-1:0]              sum_d, shifted;
	logic [pvc_pkg::AW-1:0]                 ang_r;

	always_comb begin
		xm = pvc_pkg::XMagW'(in_vec.x);
		pl = xl_s1 * Gain;
		sum_d = (pvc_pkg::ProdW'(ph_s1) << pvc_pkg::MSplit)
			+ pvc_pkg::ProdW'(pl)
			+ (pvc_pkg::ProdW'(1) << (tot_s1 - pvc_pkg::TotW'(1)));
		shifted = sum_s2 >> tot_s2;
		ang_r = ang_s2 + pvc_pkg::BearingHalf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1   <= xm[pvc_pkg::XMagW-1:pvc_pkg::MSplit] * Gain;
		xl_s1   <= xm[pvc_pkg::MSplit-1:0];
		tot_s1  <= pvc_pkg::TotW'(FRAC_BITS) + pvc_pkg::TotW'(in_side.shift);
		ang_s1  <= in_vec.ang;
		zero_s1 <= in_side.zero;
		sum_s2  <= sum_d;
		tot_s2  <= tot_s1;
		ang_s2  <= ang_s1;
		zero_s2 <= zero_s1;
		if (zero_s2) begin
			bearing <= '0;
			length  <= '0;
		end else begin
			bearing <= ang_r[pvc_pkg::AW-1 -: pvc_pkg::BrW];
			length  <= (|shifted[pvc_pkg::ProdW-1:pvc_pkg::LenW]) ? '1
				: shifted[pvc_pkg::LenW-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/polar_vector_cordic_core.sv */
// Top level of the polar vector CORDIC core: bearing and length of (x, z).
// Depends on pvc_pkg, pvc_norm, pvc_cell, pvc_scale.
//
//  channel   ports                      accepted when
//  request   start, x_raw, z_raw        start && !busy at a rising edge
//  result    done, bearing, length      done high, one cycle, no hold-off
//
// A request is taken every cycle; busy stays low.
// The pipeline has three front stages (magnitude, shift search, normalize and
// fold), one cell per iteration and three scaling stages.
// Reset clears the valid chain only; no request in flight survives it.
`default_nettype none

module polar_vector_cordic_core #(
	parameter int ITERATIONS = 30,
	parameter int INTERNAL_FRACTION_BITS = 30
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [pvc_pkg::InW-1:0]    x_raw,
	input  wire logic signed [pvc_pkg::InW-1:0]    z_raw,
	output logic                                   done,
	output logic [pvc_pkg::BrW-1:0]                bearing,
	output logic [pvc_pkg::LenW-1:0]               length
);

	logic           valid_c [ITERATIONS+1];
	pvc_pkg::vec_t  vec_c   [ITERATIONS+1];
	pvc_pkg::side_t side_c  [ITERATIONS+1];

	assign busy = 1'b0;

	pvc_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.x_raw     (x_raw),
		.z_raw     (z_raw),
		.out_valid (valid_c[0]),
		.out_vec   (vec_c[0]),
		.out_side  (side_c[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		pvc_cell #(.STEP(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_vec    (vec_c[i]),
			.in_side   (side_c[i]),
			.out_valid (valid_c[i+1]),
			.out_vec   (vec_c[i+1]),
			.out_side  (side_c[i+1])
		);
	end

	pvc_scale #(.FRAC_BITS(INTERNAL_FRACTION_BITS)) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[ITERATIONS]),
		.in_vec   (vec_c[ITERATIONS]),
		.in_side  (side_c[ITERATIONS]),
		.done     (done),
		.bearing  (bearing),
		.length   (length)
	);

endmodule

`default_nettype wire

/* rtl/pvc_checker.sv */
// Port-level checks for the polar vector CORDIC core, bound to the top level.
// Depends on pvc_pkg and polar_vector_cordic_core.
`default_nettype none

module pvc_checker #(
	parameter int LAT = 36
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic [pvc_pkg::InW-1:0]        x_raw,
	input wire logic [pvc_pkg::InW-1:0]        z_raw,
	input wire logic                           done,
	input wire logic [pvc_pkg::BrW-1:0]        bearing,
	input wire logic [pvc_pkg::LenW-1:0]       length
);

	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request without result at fixed latency");

	a_result_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, LAT))
		else $error("result strobe without matching request");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(x_raw == '0 && z_raw == '0, LAT) |-> bearing == '0 && length == '0)
		else $error("zero vector did not give zero result");

endmodule

bind polar_vector_cordic_core pvc_checker #(.LAT(ITERATIONS + 6)) u_pvc_checker (.*);

`default_nettype wire
